// File: hw/rtl/tlcaq_pkg.sv
// Package for the tree LCA distance / kth query unit.
// Holds function codes and sequencer-independent constants; no dependencies.
package tlcaq_pkg;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_DIST = 2'd1;
    localparam logic [1:0] FUNC_KTH  = 2'd2;

    localparam int DIST_BITS = 30;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Saturating add of two path sums.
    function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
                                                     input logic [DIST_BITS-1:0] b);
        logic [DIST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_BITS] ? DIST_MAX : s[DIST_BITS-1:0];
    endfunction

endpackage

// File: hw/rtl/tree_lca_distance_kth_query_unit.sv
// Binary-lifting LCA engine: loads tree nodes, answers path distance and kth-node queries.
// Depends on tlcaq_pkg. Depth, ancestor and distance tables are internal memories.
// A load keeps in_stall high while its row is filled; a query result waits on the table
// read port shared by the ancestor and distance tables and on three dependent climbs. One
// item at a time; in_stall is high from acceptance until the result is taken. Reset clears
// the sequencer and output valid only.
module tree_lca_distance_kth_query_unit #(
    parameter int MAX_NODES   = 16384,
    parameter int JUMP_LEVELS = 14,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [13:0] node_a,
    input  logic [13:0] node_b,
    input  logic        is_root,
    input  logic [15:0] edge_weight,
    input  logic [14:0] kth,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] result_value,
    output logic        is_error
);
    import tlcaq_pkg::*;

    localparam int NB = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int LB = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int DB = NB + 1;
    localparam int DEPTH_MAX = MAX_NODES - 1;
    localparam int ENTRIES = MAX_NODES * JUMP_LEVELS;
    localparam int AB = $clog2(ENTRIES);
    localparam logic [15:0] W_MASK =
        (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((1 << WEIGHT_BITS) - 1);

    typedef logic [NB-1:0] node_t;
    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [JUMP_LEVELS-1:0] steps_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_DEP, S_LD_DEPW, S_LD_ROW, S_LD_MID, S_LD_MIDW, S_LD_NEXT,
        S_Q_DEP, S_Q_DEPW, S_Q_DEPB, S_Q_DEPBW, S_CL_RD, S_CL_RW, S_CL_DONE,
        S_M_RD, S_M_RW, S_M_RDQ, S_M_RQW, S_M_FIN, S_M_FRD, S_M_FRW, S_M_FRQ, S_M_FQW,
        S_K_SET, S_OUT
    } state_t;

    // Memories.
    logic [NB-1:0]    depth_mem [MAX_NODES];
    logic [NB-1:0]    anc_mem   [ENTRIES];
    dist_t            dst_mem   [ENTRIES];

    state_t state_reg;
    logic [1:0] func_reg;
    node_t a_reg, b_reg, p_reg, q_reg, mid_reg, pa_reg;
    logic root_reg;
    dist_t w_reg, dist_reg, dv_reg, pd_reg;
    logic [14:0] k_reg;
    logic [NB-1:0] dep_reg, da_reg, d_reg;
    logic [NB:0] ea_reg, eb_reg;
    steps_t steps_reg;
    logic [LB-1:0] lvl_reg;
    logic cl_side_reg;   // climb applies to q when set
    logic kth_phase_reg; // climb is the final kth climb
    logic [29:0] res_reg;
    logic err_reg, ov_reg;

    // Read port registers.
    logic [NB-1:0] dep_rd;
    logic [NB-1:0] anc_rd;
    dist_t dst_rd;
    logic [NB-1:0] dep_addr;
    logic [AB-1:0] rd_addr, wr_addr;
    logic wr_en;
    node_t wr_anc;
    dist_t wr_dst;
    logic dep_we;
    logic [NB-1:0] dep_wd;

    function automatic logic [AB-1:0] at(input node_t n, input logic [LB-1:0] j);
        return AB'(n * JUMP_LEVELS) + AB'(j);
    endfunction

    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign result_value = res_reg;
    assign is_error = err_reg;

    // Address selection for the shared read port.
    always_comb
    begin
        dep_addr = a_reg;
        rd_addr = at(p_reg, lvl_reg);
        case (state_reg)
            S_LD_DEP:  dep_addr = b_reg;
            S_Q_DEPB:  dep_addr = b_reg;
            S_LD_MID:  rd_addr = at(mid_reg, lvl_reg - LB'(1));
            S_CL_RD:   rd_addr = at(cl_side_reg ? q_reg : p_reg, lvl_reg);
            S_M_RDQ, S_M_FRQ: rd_addr = at(q_reg, lvl_reg);
            S_M_FRD:   rd_addr = at(p_reg, '0);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dep_rd <= depth_mem[dep_addr];
        anc_rd <= anc_mem[rd_addr];
        dst_rd <= dst_mem[rd_addr];
        if (wr_en)
        begin
            anc_mem[wr_addr] <= wr_anc;
            dst_mem[wr_addr] <= wr_dst;
        end
        if (dep_we)
            depth_mem[a_reg] <= dep_wd;
    end

    // Table writes during load; the depth goes in with level zero.
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = at(a_reg, lvl_reg);
        wr_anc = a_reg;
        wr_dst = '0;
        dep_we = 1'b0;
        dep_wd = dep_reg;
        case (state_reg)
            S_LD_ROW:
            begin
                dep_we = (lvl_reg == '0);
                wr_en = 1'b1;
                if (root_reg || (lvl_reg != '0 && (DB'(dep_reg) >> lvl_reg) == '0))
                begin
                    wr_anc = a_reg;
                    wr_dst = '0;
                end
                else if (lvl_reg == '0)
                begin
                    wr_anc = b_reg;
                    wr_dst = w_reg;
                end
                else
                    wr_en = 1'b0;
            end
            S_LD_MIDW:
            begin
                wr_en = 1'b1;
                wr_anc = anc_rd;
                wr_dst = sat_add(dv_reg, dst_rd);
            end
            default: ;
        endcase
    end

    logic [NB:0] span;
    logic [15:0] total;
    always_comb
    begin
        span = ea_reg + eb_reg;
        total = 16'(span) + 16'd1;
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (ov_reg && !out_stall)
                        ov_reg <= 1'b0;
                    if (in_valid && !(ov_reg && out_stall))
                    begin
                        func_reg <= func;
                        a_reg <= NB'(node_a);
                        b_reg <= NB'(node_b);
                        root_reg <= is_root;
                        w_reg <= DIST_BITS'(edge_weight & W_MASK);
                        k_reg <= kth;
                        if (func == FUNC_LOAD)
                            state_reg <= S_LD_DEP;
                        else if (func == FUNC_DIST || func == FUNC_KTH)
                            state_reg <= S_Q_DEP;
                    end
                end
                // Load: depth from parent, then fill row level by level.
                S_LD_DEP: state_reg <= S_LD_DEPW;
                S_LD_DEPW:
                begin
                    if (root_reg)
                        dep_reg <= '0;
                    else
                        dep_reg <= (dep_rd >= NB'(DEPTH_MAX)) ? NB'(DEPTH_MAX) : dep_rd + NB'(1);
                    lvl_reg <= '0;
                    state_reg <= S_LD_ROW;
                end
                S_LD_ROW:
                begin
                    // The entry written here is the midpoint for the next level.
                    if (wr_en)
                    begin
                        mid_reg <= wr_anc;
                        dv_reg <= wr_dst;
                        state_reg <= S_LD_NEXT;
                    end
                    else
                        state_reg <= S_LD_MID;
                end
                S_LD_NEXT:
                begin
                    if (lvl_reg == LB'(JUMP_LEVELS - 1))
                        state_reg <= S_IDLE;
                    else
                    begin
                        lvl_reg <= lvl_reg + LB'(1);
                        state_reg <= S_LD_ROW;
                    end
                end
                // Read the midpoint's entry one level down.
                S_LD_MID: state_reg <= S_LD_MIDW;
                S_LD_MIDW:
                begin
                    mid_reg <= wr_anc;
                    dv_reg <= wr_dst;
                    state_reg <= S_LD_NEXT;
                end
                // Query: read both depths.
                S_Q_DEP: state_reg <= S_Q_DEPW;
                S_Q_DEPW:
                begin
                    da_reg <= dep_rd;
                    state_reg <= S_Q_DEPB;
                end
                S_Q_DEPB: state_reg <= S_Q_DEPBW;
                S_Q_DEPBW:
                begin
                    p_reg <= a_reg;
                    q_reg <= b_reg;
                    dist_reg <= '0;
                    kth_phase_reg <= 1'b0;
                    lvl_reg <= LB'(JUMP_LEVELS - 1);
                    if (da_reg > dep_rd)
                    begin
                        ea_reg <= (NB+1)'(steps_t'(da_reg - dep_rd));
                        eb_reg <= '0;
                        steps_reg <= steps_t'(da_reg - dep_rd);
                        d_reg <= dep_rd;
                        cl_side_reg <= 1'b0;
                    end
                    else
                    begin
                        eb_reg <= (NB+1)'(steps_t'(dep_rd - da_reg));
                        ea_reg <= '0;
                        steps_reg <= steps_t'(dep_rd - da_reg);
                        d_reg <= da_reg;
                        cl_side_reg <= 1'b1;
                    end
                    state_reg <= S_CL_RD;
                end
                // Climb by set bits of steps_reg, high level first.
                S_CL_RD:
                begin
                    if (steps_reg[lvl_reg])
                        state_reg <= S_CL_RW;
                    else if (lvl_reg == '0)
                        state_reg <= S_CL_DONE;
                    else
                        lvl_reg <= lvl_reg - LB'(1);
                end
                S_CL_RW:
                begin
                    dist_reg <= sat_add(dist_reg, dst_rd);
                    if (cl_side_reg)
                        q_reg <= anc_rd;
                    else
                        p_reg <= anc_rd;
                    if (lvl_reg == '0)
                        state_reg <= S_CL_DONE;
                    else
                    begin
                        lvl_reg <= lvl_reg - LB'(1);
                        state_reg <= S_CL_RD;
                    end
                end
                S_CL_DONE:
                begin
                    lvl_reg <= LB'(JUMP_LEVELS - 1);
                    if (kth_phase_reg)
                    begin
                        res_reg <= 30'(cl_side_reg ? q_reg : p_reg);
                        err_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (p_reg == q_reg)
                        state_reg <= S_M_FIN;
                    else
                        state_reg <= S_M_RD;
                end
                // Joint lifting of both sides.
                S_M_RD:
                begin
                    if ((DB'(d_reg) >> lvl_reg) != '0)
                        state_reg <= S_M_RW;
                    else if (lvl_reg == '0)
                        state_reg <= S_M_FRD;
                    else
                        lvl_reg <= lvl_reg - LB'(1);
                end
                S_M_RW:
                begin
                    pa_reg <= anc_rd;
                    pd_reg <= dst_rd;
                    state_reg <= S_M_RDQ;
                end
                S_M_RDQ: state_reg <= S_M_RQW;
                S_M_RQW:
                begin
                    if (pa_reg != anc_rd)
                    begin
                        dist_reg <= sat_add(sat_add(dist_reg, pd_reg), dst_rd);
                        p_reg <= pa_reg;
                        q_reg <= anc_rd;
                        ea_reg <= ea_reg + ((NB+1)'(1) << lvl_reg);
                        eb_reg <= eb_reg + ((NB+1)'(1) << lvl_reg);
                        d_reg <= d_reg - (NB'(1) << lvl_reg);
                    end
                    if (lvl_reg == '0)
                        state_reg <= S_M_FRD;
                    else
                    begin
                        lvl_reg <= lvl_reg - LB'(1);
                        state_reg <= S_M_RD;
                    end
                end
                S_M_FRD:
                begin
                    lvl_reg <= '0;
                    if (d_reg == '0)
                    begin
                        res_reg <= '0;
                        err_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_M_FRW;
                end
                S_M_FRW:
                begin
                    pd_reg <= dst_rd;
                    state_reg <= S_M_FRQ;
                end
                S_M_FRQ: state_reg <= S_M_FQW;
                S_M_FQW:
                begin
                    dist_reg <= sat_add(sat_add(dist_reg, pd_reg), dst_rd);
                    ea_reg <= ea_reg + (NB+1)'(1);
                    eb_reg <= eb_reg + (NB+1)'(1);
                    state_reg <= S_M_FIN;
                end
                S_M_FIN:
                begin
                    if (func_reg == FUNC_DIST)
                    begin
                        res_reg <= dist_reg;
                        err_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (k_reg == '0 || 16'(k_reg) > total)
                    begin
                        res_reg <= '0;
                        err_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_K_SET;
                end
                // Final kth climb from the proper endpoint.
                S_K_SET:
                begin
                    kth_phase_reg <= 1'b1;
                    lvl_reg <= LB'(JUMP_LEVELS - 1);
                    p_reg <= a_reg;
                    q_reg <= b_reg;
                    if (16'(k_reg) - 16'd1 <= 16'(ea_reg))
                    begin
                        cl_side_reg <= 1'b0;
                        steps_reg <= steps_t'(k_reg - 15'd1);
                    end
                    else
                    begin
                        cl_side_reg <= 1'b1;
                        steps_reg <= steps_t'(16'(eb_reg) - (16'(k_reg) - 16'd1 - 16'(ea_reg)));
                    end
                    state_reg <= S_CL_RD;
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: test/tree_lca_distance_kth_query_unit_tb.sv
// Testbench for the tree LCA distance / kth query unit: a directed table, then random
// forests of distance and kth queries; untyped rows checked by a binary-lifting predictor.
// Depends on tlcaq_pkg and tree_lca_distance_kth_query_unit.
`timescale 1ns / 1ps

module tree_lca_distance_kth_query_unit_tb;
    import tlcaq_pkg::*;

    localparam int NODES = 16384;
    localparam int LEVELS = 14;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int unsigned SUM_MAX = 32'h3FFF_FFFF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 830;
    localparam int DIRECTED_ITEMS = 21;
    localparam int ANSWER_SLOTS = 1024;

    typedef struct {
        logic [1:0]  func;
        logic [13:0] a;
        logic [13:0] b;
        logic        root;
        logic [15:0] w;
        logic [14:0] k;
        bit          typed;
        logic [29:0] tval;
        logic        terr;
    } query_item_t;

    typedef struct {
        logic [29:0] value;
        logic        err;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [13:0] node_a;
    logic [13:0] node_b;
    logic        is_root;
    logic [15:0] edge_weight;
    logic [14:0] kth;
    logic        out_valid;
    logic        out_stall;
    logic [29:0] result_value;
    logic        is_error;

    // Shadow copy of the lifting tables.
    int unsigned depth_tab [NODES];
    int unsigned up_tab [NODES][LEVELS];
    int unsigned len_tab [NODES][LEVELS];
    bit          loaded [NODES];
    int          loaded_list [NODES];
    int          loaded_count;
    int          last_loaded;

    // Expected results as a ring of slots between head and tail.
    answer_t     answers_due [ANSWER_SLOTS];
    int          due_head;
    int          due_tail;
    query_item_t directed [DIRECTED_ITEMS];
    int          dir_count;
    int          errors;
    int          cycles;

    tree_lca_distance_kth_query_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .node_a       (node_a),
        .node_b       (node_b),
        .is_root      (is_root),
        .edge_weight  (edge_weight),
        .kth          (kth),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .is_error     (is_error)
    );

    // Clock: 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned sum_sat(input int unsigned x, input int unsigned y);
        longint unsigned s;
        s = longint'(x) + longint'(y);
        return (s > SUM_MAX) ? SUM_MAX : 32'(s);
    endfunction

    // Climb the given number of edges (low LEVELS bits), adding weight to acc.
    function automatic int unsigned hop_up(input int unsigned n, input int unsigned steps,
                                           inout int unsigned acc);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (steps[i])
            begin
                acc = sum_sat(acc, len_tab[n][i]);
                n = up_tab[n][i];
            end
        end
        return n;
    endfunction

    // Find the meeting point of two nodes; edges climbed from each side and path weight.
    function automatic bit find_meeting(input int unsigned a, input int unsigned b,
                                        output int unsigned ea, output int unsigned eb,
                                        output int unsigned sum);
        int unsigned p, q, d, stp;
        p = a;
        q = b;
        ea = 0;
        eb = 0;
        sum = 0;
        if (depth_tab[a] > depth_tab[b])
        begin
            ea = (depth_tab[a] - depth_tab[b]) & ((1 << LEVELS) - 1);
            p = hop_up(p, ea, sum);
            d = depth_tab[b];
        end
        else
        begin
            eb = (depth_tab[b] - depth_tab[a]) & ((1 << LEVELS) - 1);
            q = hop_up(q, eb, sum);
            d = depth_tab[a];
        end
        if (p == q)
            return 1'b1;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            stp = 1 << i;
            if (d >= stp && up_tab[p][i] != up_tab[q][i])
            begin
                sum = sum_sat(sum, len_tab[p][i]);
                sum = sum_sat(sum, len_tab[q][i]);
                p = up_tab[p][i];
                q = up_tab[q][i];
                ea += stp;
                eb += stp;
                d -= stp;
            end
        end
        if (d == 0)
            return 1'b0;
        sum = sum_sat(sum, len_tab[p][0]);
        sum = sum_sat(sum, len_tab[q][0]);
        ea += 1;
        eb += 1;
        return 1'b1;
    endfunction

    // Apply one accepted item to the shadow tables; returns 1 when it yields an answer.
    function automatic bit predict_answer(input query_item_t it, output answer_t ans);
        int unsigned v, dep, mid, ea, eb, sum, k, n;
        ans.value = '0;
        ans.err = 1'b1;
        v = it.a;
        if (it.func == FUNC_LOAD)
        begin
            if (!loaded[v])
            begin
                loaded_list[loaded_count] = int'(v);
                loaded_count++;
            end
            loaded[v] = 1'b1;
            last_loaded = v;
            if (it.root)
            begin
                depth_tab[v] = 0;
                for (int j = 0; j < LEVELS; j++)
                begin
                    up_tab[v][j] = v;
                    len_tab[v][j] = 0;
                end
                return 1'b0;
            end
            dep = depth_tab[it.b];
            dep = (dep >= NODES - 1) ? NODES - 1 : dep + 1;
            depth_tab[v] = dep;
            up_tab[v][0] = it.b;
            len_tab[v][0] = it.w;
            for (int j = 1; j < LEVELS; j++)
            begin
                if (dep >= (1 << j))
                begin
                    mid = up_tab[v][j-1];
                    up_tab[v][j] = up_tab[mid][j-1];
                    len_tab[v][j] = sum_sat(len_tab[v][j-1], len_tab[mid][j-1]);
                end
                else
                begin
                    up_tab[v][j] = v;
                    len_tab[v][j] = 0;
                end
            end
            return 1'b0;
        end
        if (it.func == FUNC_NONE)
            return 1'b0;
        if (!find_meeting(it.a, it.b, ea, eb, sum))
            return 1'b1;
        if (it.func == FUNC_DIST)
        begin
            ans.value = 30'(sum);
            ans.err = 1'b0;
            return 1'b1;
        end
        k = it.k;
        if (k == 0 || k > ea + eb + 1)
            return 1'b1;
        k -= 1;
        sum = 0;
        if (k <= ea)
            n = hop_up(it.a, k, sum);
        else
            n = hop_up(it.b, eb - (k - ea), sum);
        ans.value = 30'(n);
        ans.err = 1'b0;
        return 1'b1;
    endfunction

    function automatic query_item_t make_row(input logic [1:0] f, input int a, input int b,
                                             input bit r, input int w, input int k,
                                             input bit typed, input int tv, input bit te);
        query_item_t it;
        it.func = f;
        it.a = 14'(a);
        it.b = 14'(b);
        it.root = r;
        it.w = 16'(w);
        it.k = 15'(k);
        it.typed = typed;
        it.tval = 30'(tv);
        it.terr = te;
        return it;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input query_item_t it);
        directed[dir_count] = it;
        dir_count++;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_count - 1)];
    endfunction

    // Random item: mostly well-formed loads and queries over loaded nodes.
    function automatic query_item_t random_item();
        query_item_t it;
        int unsigned sel, ea, eb, sum;
        it = make_row(FUNC_LOAD, $urandom_range(0, NODES - 1), 0, 1'b0,
                      $urandom_range(0, 65535), $urandom_range(0, 32767), 1'b0, 0, 1'b0);
        if ($urandom_range(0, 3) == 0)
            it.w = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            // New node under a recent node, a random one, or as a new root.
            if ($urandom_range(0, 9) == 0)
                it.a = 14'(pick_loaded());
            if (sel < 2)
                it.root = 1'b1;
            else if (sel < 22)
                it.b = 14'(last_loaded);
            else
                it.b = 14'(pick_loaded());
            if (it.root)
                it.b = 14'($urandom_range(0, NODES - 1));
        end
        else if (sel < 95)
        begin
            it.func = (sel < 65) ? FUNC_DIST : FUNC_KTH;
            it.a = 14'(pick_loaded());
            it.b = ($urandom_range(0, 4) == 0) ? 14'(last_loaded) : 14'(pick_loaded());
            it.root = 1'($urandom_range(0, 1));
            if (it.func == FUNC_KTH && $urandom_range(0, 4) != 0)
            begin
                void'(find_meeting(it.a, it.b, ea, eb, sum));
                it.k = 15'(($urandom_range(0, 9) == 0) ? ea + eb + 2
                                                       : $urandom_range(1, ea + eb + 1));
            end
        end
        else
        begin
            it.func = FUNC_NONE;
            it.root = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    // Drive one item from the falling edge until it is accepted, then predict it.
    task automatic send_item(input query_item_t it);
        answer_t ans;
        @(negedge clk);
        in_valid = 1'b1;
        func = it.func;
        node_a = it.a;
        node_b = it.b;
        is_root = it.root;
        edge_weight = it.w;
        kth = it.k;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        if (predict_answer(it, ans))
        begin
            if (it.typed)
            begin
                ans.value = it.tval;
                ans.err = it.terr;
            end
            answers_due[due_tail % ANSWER_SLOTS] = ans;
            due_tail++;
        end
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Receiver stall pattern: windows of none, light, heavy and periodic stalling.
    always @(negedge clk)
    begin
        case ((cycles / 300) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((cycles % 7) < 3);
        endcase
    end

    // Result checker.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_head == due_tail)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual value=%0d err=%0b",
                         $time, result_value, is_error);
            end
            else
            begin
                if (result_value !== answers_due[due_head % ANSWER_SLOTS].value)
                begin
                    errors++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             answers_due[due_head % ANSWER_SLOTS].value, result_value);
                end
                if (is_error !== answers_due[due_head % ANSWER_SLOTS].err)
                begin
                    errors++;
                    $display("%0t: is_error expected %0b actual %0b", $time,
                             answers_due[due_head % ANSWER_SLOTS].err, is_error);
                end
                due_head++;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int burst;
        errors = 0;
        cycles = 0;
        last_loaded = 0;
        loaded_count = 0;
        due_head = 0;
        due_tail = 0;
        dir_count = 0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = FUNC_LOAD;
        node_a = '0;
        node_b = '0;
        is_root = 1'b0;
        edge_weight = '0;
        kth = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: extremes, both trees, every function and error case.
        add_row(make_row(FUNC_LOAD, 0, 16383, 1, 65535, 0, 0, 0, 0));
        add_row(make_row(FUNC_LOAD, 1, 0, 0, 65535, 0, 0, 0, 0));
        add_row(make_row(FUNC_LOAD, 2, 1, 0, 0, 0, 0, 0, 0));
        add_row(make_row(FUNC_LOAD, 16383, 0, 0, 5, 0, 0, 0, 0));
        add_row(make_row(FUNC_LOAD, 8191, 2, 0, 65535, 0, 0, 0, 0));
        add_row(make_row(FUNC_DIST, 0, 0, 0, 0, 0, 1, 0, 0));
        add_row(make_row(FUNC_DIST, 1, 2, 0, 0, 0, 1, 0, 0));
        add_row(make_row(FUNC_DIST, 16383, 2, 1, 0, 0, 1, 65540, 0));
        add_row(make_row(FUNC_DIST, 8191, 16383, 0, 0, 0, 0, 0, 0));
        add_row(make_row(FUNC_KTH, 16383, 2, 0, 0, 0, 1, 0, 1));
        add_row(make_row(FUNC_KTH, 16383, 2, 0, 0, 1, 1, 16383, 0));
        add_row(make_row(FUNC_KTH, 16383, 2, 0, 0, 4, 1, 2, 0));
        add_row(make_row(FUNC_KTH, 16383, 2, 0, 0, 5, 1, 0, 1));
        add_row(make_row(FUNC_KTH, 16383, 2, 0, 0, 32767, 1, 0, 1));
        add_row(make_row(FUNC_KTH, 2, 8191, 0, 0, 16384, 1, 0, 1));
        add_row(make_row(FUNC_KTH, 8191, 16383, 1, 0, 3, 0, 0, 0));
        add_row(make_row(FUNC_LOAD, 100, 0, 1, 0, 0, 0, 0, 0));
        add_row(make_row(FUNC_DIST, 100, 2, 0, 0, 0, 1, 0, 1));
        add_row(make_row(FUNC_KTH, 2, 100, 0, 0, 1, 1, 0, 1));
        add_row(make_row(FUNC_NONE, 16383, 16383, 1, 65535, 32767, 0, 0, 0));
        add_row(make_row(FUNC_DIST, 100, 100, 0, 0, 0, 1, 0, 0));
        for (int i = 0; i < dir_count; i++)
            send_item(directed[i]);

        // Random part in bursts with gaps; one full drain midway.
        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 12));
            end
            burst--;
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                while (due_head != due_tail)
                    @(negedge clk);
            end
            send_item(random_item());
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (due_head != due_tail)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && due_head == due_tail)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tlcaq_pkg.sv
hw/rtl/tree_lca_distance_kth_query_unit.sv
test/tree_lca_distance_kth_query_unit_tb.sv
